// ===== sv/sspc_pkg.sv =====
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types and constants of the sample stream prefetch controller.
// ----------------------------------------------------------------------------
package sspc_pkg;

    localparam int BLOCK_SAMPLES = 2048;
    localparam int BUF_BLOCKS    = 14;
    localparam int RECORDS       = 8;
    localparam int SLOTS         = 7;

    localparam int OFFSET_W  = 32;
    localparam int BLK_W     = 21;
    localparam int OFF_W     = $clog2(BLOCK_SAMPLES);
    localparam int DIFF_W    = $clog2(BUF_BLOCKS);
    localparam int IDX_W     = 15;
    localparam int REC_W     = 3;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Reciprocal used to align the loop start to a whole buffer.
    localparam int DIV_SH  = 28;
    localparam int DIV_MUL = (2**DIV_SH + BUF_BLOCKS - 1) / BUF_BLOCKS;

    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPED     = 3'd3;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_DONE    = 1'b1;
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_START = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_LOOP1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_LOOP2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_ROT0  = 3'd3;

    typedef struct packed {
        logic                command;
        logic [OFFSET_W-1:0] sample_offset;
        logic [REC_W-1:0]    done_record;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic             hit;
        logic [REC_W-1:0] record;
        logic [IDX_W-1:0] sample_index;
        logic [BLK_W-1:0] read_block;
        logic             last;
    } t_out;

    typedef struct packed {
        logic             is_done;
        logic [BLK_W-1:0] blk;
        logic [OFF_W-1:0] ind;
        logic [REC_W-1:0] rec;
    } t_job;

    typedef struct packed {
        logic [BLK_W-1:0] start_blk;
        logic [BLK_W-1:0] end_blk;
        logic             looped;
        logic [BLK_W-1:0] loop_first;
    } t_cfg;

endpackage

// ===== sv/sample_stream_prefetch_control_core.sv =====
// ----------------------------------------------------------------------------
// sample_stream_prefetch_control_core
// Sequence: a hit passes queue pop, one to four probe steps, three read-issue
// steps and one answer step; read and answer steps wait while the output is
// held. A miss is answered after a single probe in a fixed window, else after
// four. Completions: one per cycle while the back-end sequencer is idle; it
// handles one word at a time and takes no new word until done with the last.
// Reset: synchronous, active low; only the start buffer is present and ready.
// ----------------------------------------------------------------------------
module sample_stream_prefetch_control_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sspc_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sspc_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sspc_pkg::BLK_W-1:0]       i_cfg_data
);
    import sspc_pkg::*;

    logic [BLK_W-1:0]        r_start;
    logic [BLK_W-1:0]        r_end;
    logic [BLK_W-1:0]        r_lstart;
    logic                    r_looped;
    logic [BLK_W-1:0]        r_lfb;
    logic [BLK_W-1:0]        w_d;
    logic [BLK_W+DIV_SH-1:0] w_prod;
    logic [BLK_W-1:0]        w_q;
    logic [BLK_W-1:0]        w_lfb;
    logic                    w_cfg_wr;
    logic                    w_job_valid;
    logic                    w_job_pop;
    t_job                    w_job;
    t_cfg                    w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Loop start aligned down to a whole buffer past the start block.
    assign w_d    = r_lstart - r_start;
    assign w_prod = (BLK_W+DIV_SH)'(w_d) * (BLK_W+DIV_SH)'(DIV_MUL);
    assign w_q    = w_prod[BLK_W+DIV_SH-1:DIV_SH];
    assign w_lfb  = BLK_W'(w_q * BLK_W'(BUF_BLOCKS)) + r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_end    <= '0;
            r_lstart <= '0;
            r_looped <= 1'b0;
            r_lfb    <= '0;
        end else begin
            r_lfb <= r_looped ? w_lfb : '0;
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    CFG_START:      r_start  <= i_cfg_data;
                    CFG_END:        r_end    <= i_cfg_data;
                    CFG_LOOP_START: r_lstart <= i_cfg_data;
                    CFG_LOOPED:     r_looped <= i_cfg_data[0];
                    default:        r_looped <= r_looped;
                endcase
            end
        end
    end

    always_comb begin
        w_cfg.start_blk  = r_start;
        w_cfg.end_blk    = r_end;
        w_cfg.looped     = r_looped;
        w_cfg.loop_first = r_lfb;
    end

    sspc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    sspc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/sspc_front.sv =====
// ----------------------------------------------------------------------------
// sspc_front
// Accepts input words, splits the offset into block and index, and queues
// them for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module sspc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sspc_pkg::t_in  i_in_data,
    output logic           o_job_valid,
    output sspc_pkg::t_job o_job,
    input  logic           i_job_pop
);
    import sspc_pkg::*;

    t_job       r_q [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_job_pop && o_job_valid;

    always_comb begin
        w_job.is_done = (i_in_data.command == CMD_DONE);
        w_job.blk     = i_in_data.sample_offset[OFFSET_W-1:OFF_W];
        w_job.ind     = i_in_data.sample_offset[OFF_W-1:0];
        w_job.rec     = i_in_data.done_record;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

// ===== sv/sspc_back.sv =====
// ----------------------------------------------------------------------------
// sspc_back
// Resolves one queued word at a time: probes the buffer windows, issues the
// follow-on reads, and answers the request through an output register.
// ----------------------------------------------------------------------------
module sspc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  sspc_pkg::t_job i_job,
    output logic           o_job_pop,
    input  sspc_pkg::t_cfg i_cfg,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sspc_pkg::t_out o_out_data
);
    import sspc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_REQ   = 2'd2;
    localparam logic [1:0] ST_ANS   = 2'd3;

    logic [1:0]        r_st;
    logic [BLK_W-1:0]  r_blk;
    logic [OFF_W-1:0]  r_ind;
    logic [1:0]        r_p;
    logic [1:0]        r_k;
    logic              r_fixed;
    logic [SLOT_W-1:0] r_c;
    logic [BLK_W:0]    r_nblk;
    logic [BLK_W-1:0]  r_bblk;
    logic [REC_W-1:0]  r_rec;
    logic              r_hit;
    logic [REC_W-1:0]  r_slot_rec [0:SLOTS-1];
    logic [SLOTS-1:0]  r_slot_pres;
    logic [RECORDS-1:0] r_ready;
    logic [BLK_W-1:0]  r_base [0:RECORDS-1];
    logic              r_ov;
    t_out              r_od;

    logic [RECORDS-1:0] w_live;
    logic [REC_W-1:0]   w_pick;
    logic [SLOT_W-1:0]  w_n;
    logic [SLOT_W-1:0]  w_sa;
    logic [REC_W-1:0]   w_srec;
    logic               w_spres;
    logic [BLK_W-1:0]   w_sbase;
    logic [BLK_W:0]     w_bend;
    logic               w_probe_hit;
    logic [BLK_W:0]     w_sw_end;
    logic [BLK_W:0]     w_l1_end;
    logic [BLK_W:0]     w_l2_end;
    logic               w_in_start;
    logic               w_in_l1;
    logic               w_in_l2;
    logic               w_skip;
    logic               w_isl1;
    logic               w_isl2;
    logic               w_isl;
    logic [SLOT_W-1:0]  w_ls;
    logic               w_ls_pres;
    logic [REC_W-1:0]   w_ls_rec;
    logic               w_need;
    logic               w_oload;
    logic               w_req_go;
    logic               w_oset;
    logic [SLOTS-1:0]   w_n_bit;
    logic [SLOTS-1:0]   w_ls_bit;
    t_out               w_read;
    t_out               w_ans;

    // A record is live while any present slot names it.
    always_comb begin
        w_live = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_slot_pres[i]) begin
                w_live[r_slot_rec[i]] = 1'b1;
            end
        end
    end

    // New reads take the lowest free record other than the start record.
    always_comb begin
        w_pick = REC_W'(1);
        for (int r = RECORDS - 1; r >= 1; r--) begin
            if (!w_live[r]) begin
                w_pick = REC_W'(r);
            end
        end
    end

    assign w_n     = SLOT_ROT0 + {1'b0, 2'(r_p + 2'd1 + r_k)};
    assign w_sa    = (r_st == ST_PROBE) ? r_c : w_n;
    assign w_srec  = r_slot_rec[w_sa];
    assign w_spres = r_slot_pres[w_sa];
    assign w_sbase = (w_srec == '0) ? i_cfg.start_blk : r_base[w_srec];
    assign w_bend  = {1'b0, w_sbase} + (BLK_W+1)'(BUF_BLOCKS);

    assign w_probe_hit = w_spres && (r_blk >= w_sbase) && ({1'b0, r_blk} < w_bend)
                         && r_ready[w_srec];

    assign w_sw_end = {1'b0, i_cfg.start_blk} + (BLK_W+1)'(BUF_BLOCKS);
    assign w_l1_end = {1'b0, i_cfg.loop_first} + (BLK_W+1)'(BUF_BLOCKS);
    assign w_l2_end = {1'b0, i_cfg.loop_first} + (BLK_W+1)'(2 * BUF_BLOCKS);

    assign w_in_start = (i_job.blk >= i_cfg.start_blk) && ({1'b0, i_job.blk} < w_sw_end);
    assign w_in_l1    = i_cfg.looped && (i_job.blk >= i_cfg.loop_first)
                        && ({1'b0, i_job.blk} < w_l1_end);
    assign w_in_l2    = i_cfg.looped && ({1'b0, i_job.blk} >= w_l1_end)
                        && ({1'b0, i_job.blk} < w_l2_end);

    assign w_skip    = r_nblk > {1'b0, i_cfg.end_blk};
    assign w_isl1    = i_cfg.looped && (r_nblk == {1'b0, i_cfg.loop_first});
    assign w_isl2    = i_cfg.looped && (r_nblk == w_l1_end);
    assign w_isl     = w_isl1 || w_isl2;
    assign w_ls      = w_isl1 ? SLOT_LOOP1 : SLOT_LOOP2;
    assign w_ls_pres = w_isl1 ? r_slot_pres[SLOT_LOOP1] : r_slot_pres[SLOT_LOOP2];
    assign w_ls_rec  = w_isl1 ? r_slot_rec[SLOT_LOOP1] : r_slot_rec[SLOT_LOOP2];
    assign w_n_bit   = SLOTS'(1) << w_n;
    assign w_ls_bit  = SLOTS'(1) << w_ls;

    assign w_need = !w_skip && (w_isl ? !w_ls_pres
                                      : (!w_spres || ({1'b0, w_sbase} != r_nblk)));

    assign w_oload  = !r_ov || i_out_ready;
    assign w_req_go = !w_need || w_oload;
    assign w_oset   = ((r_st == ST_REQ) && w_req_go && w_need)
                      || ((r_st == ST_ANS) && w_oload);

    assign o_job_pop   = (r_st == ST_IDLE) && i_job_valid;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    always_comb begin
        w_read.kind         = KIND_READ;
        w_read.hit          = 1'b0;
        w_read.record       = w_pick;
        w_read.sample_index = '0;
        w_read.read_block   = r_nblk[BLK_W-1:0];
        w_read.last         = 1'b0;

        w_ans.kind       = KIND_ANSWER;
        w_ans.hit        = r_hit;
        w_ans.read_block = '0;
        w_ans.last       = 1'b1;
        if (r_hit) begin
            w_ans.record       = r_rec;
            w_ans.sample_index = {DIFF_W'(r_blk - r_bblk), r_ind};
        end else begin
            w_ans.record       = '0;
            w_ans.sample_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_ov        <= 1'b0;
            r_slot_pres <= SLOTS'(1);
            r_ready     <= RECORDS'(1);
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_rec[i] <= '0;
            end
        end else begin
            r_ov <= w_oset || (r_ov && !i_out_ready);
            case (r_st)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.is_done) begin
                            if ((i_job.rec != '0) && w_live[i_job.rec]) begin
                                r_ready[i_job.rec] <= 1'b1;
                            end
                        end else begin
                            r_blk <= i_job.blk;
                            r_ind <= i_job.ind;
                            r_p   <= 2'd0;
                            r_st  <= ST_PROBE;
                            if (w_in_start) begin
                                r_c     <= SLOT_START;
                                r_fixed <= 1'b1;
                            end else if (w_in_l1) begin
                                r_c     <= SLOT_LOOP1;
                                r_fixed <= 1'b1;
                            end else if (w_in_l2) begin
                                r_c     <= SLOT_LOOP2;
                                r_fixed <= 1'b1;
                            end else begin
                                r_c     <= SLOT_ROT0;
                                r_fixed <= 1'b0;
                            end
                        end
                    end
                end
                ST_PROBE: begin
                    if (w_probe_hit) begin
                        r_hit  <= 1'b1;
                        r_bblk <= w_sbase;
                        r_rec  <= w_srec;
                        r_nblk <= w_bend;
                        r_k    <= 2'd0;
                        r_st   <= ST_REQ;
                    end else if (r_fixed || (r_p == 2'd3)) begin
                        r_hit <= 1'b0;
                        r_st  <= ST_ANS;
                    end else begin
                        r_p <= r_p + 2'd1;
                        r_c <= r_c + SLOT_W'(1);
                    end
                end
                ST_REQ: begin
                    if (w_req_go) begin
                        if (w_need) begin
                            r_od            <= w_read;
                            r_ready[w_pick] <= 1'b0;
                            r_slot_rec[w_n] <= w_pick;
                            r_slot_pres     <= r_slot_pres | w_n_bit
                                               | (w_isl ? w_ls_bit : '0);
                            if (w_isl) begin
                                r_slot_rec[w_ls] <= w_pick;
                            end
                        end else if (!w_skip && w_isl) begin
                            r_slot_rec[w_n] <= w_ls_rec;
                            r_slot_pres     <= r_slot_pres | w_n_bit;
                        end
                        r_k    <= r_k + 2'd1;
                        r_nblk <= r_nblk + (BLK_W+1)'(BUF_BLOCKS);
                        if (r_k == 2'd2) begin
                            r_st <= ST_ANS;
                        end
                    end
                end
                ST_ANS: begin
                    if (w_oload) begin
                        r_od <= w_ans;
                        r_st <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == ST_REQ) && w_req_go && w_need) begin
            r_base[w_pick] <= r_nblk[BLK_W-1:0];
        end
    end

endmodule
